>>> hdl/pmw_pkg.sv
// Shared types and constants for the minimum spanning tree weight block.
// Used by pmw_ctrl, pmw_datapath and prim_mst_weight; depends on nothing.
`default_nettype none

package pmw_pkg;

  localparam int CMD_W    = 2;
  localparam int VTX_W    = 6;
  localparam int WEIGHT_W = 17;
  localparam int TOTAL_W  = 23;
  localparam int VCNT_W   = 7;

  localparam logic [VCNT_W-1:0]   VCNT_RESET = 7'd64;
  localparam logic [WEIGHT_W-1:0] NO_EDGE    = 17'd100000;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = 23'h7FFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_RUN   = 2'd2
  } command_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD0,
    ST_ADD_WR0,
    ST_ADD_RD1,
    ST_ADD_WR1,
    ST_SETUP,
    ST_INIT,
    ST_SCAN,
    ST_WAIT,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic clr_step;
    logic add_rd;
    logic add_wr;
    logic add_sel;
    logic run_setup;
    logic init_step;
    logic scan_issue;
    logic round_next;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic add_bad;
    logic start_bad;
    logic single_vertex;
    logic v_last;
    logic last_round;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/pmw_datapath.sv
// Datapath: weight matrix memory, key memory, tree flags, scan pipeline and total.
// Depends on pmw_pkg; driven by pmw_ctrl through dp_cmd_t.
`default_nettype none

module pmw_datapath import pmw_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dp_cmd_t             cmd_i,
  output dp_sts_t                  sts_o,
  input  wire logic [VTX_W-1:0]    vertex_a_i,
  input  wire logic [VTX_W-1:0]    vertex_b_i,
  input  wire logic [WEIGHT_W-1:0] edge_weight_i,
  input  wire logic [VTX_W-1:0]    start_vertex_i,
  input  wire logic                cfg_we_i,
  input  wire logic [VCNT_W-1:0]   cfg_vertex_count_i,
  output logic [TOTAL_W-1:0]       total_weight_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int MatDepth = MAX_VERTICES * MAX_VERTICES;
  localparam int AW = $clog2(MatDepth);
  localparam logic [AW-1:0] SweepLast = AW'(MatDepth - 1);

  logic [WEIGHT_W-1:0] wmat_mem [MatDepth];
  logic [WEIGHT_W-1:0] key_mem  [MAX_VERTICES];

  logic [VCNT_W-1:0]   vcount_q;
  logic [AW-1:0]       sweep_q;
  logic [VW-1:0]       v_q;
  logic [CW-1:0]       n_q;
  logic [CW-1:0]       rounds_q;
  logic                ev_valid_q;
  logic                found_q;
  logic [MAX_VERTICES-1:0] in_tree_q;

  logic [VTX_W-1:0]    a_q, b_q, start_q;
  logic [WEIGHT_W-1:0] w_q;
  logic [AW-1:0]       row_q;
  logic [VW-1:0]       ev_v_q;
  logic [WEIGHT_W-1:0] w_rd_q, k_rd_q;
  logic [VW-1:0]       best_q;
  logic [WEIGHT_W-1:0] best_key_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [TOTAL_W-1:0]  out_q;

  logic [CW-1:0]       n_c;
  logic [WEIGHT_W-1:0] w_sat;
  logic [AW-1:0]       addr_ab, addr_ba, addr_add;
  logic [AW-1:0]       mat_raddr, mat_waddr;
  logic [WEIGHT_W-1:0] mat_wdata;
  logic                mat_we;
  logic                ev_live;
  logic [WEIGHT_W-1:0] new_key;
  logic                better;
  logic                key_we;
  logic [VW-1:0]       key_waddr;
  logic [WEIGHT_W-1:0] key_wdata;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_sat;
  logic [VW-1:0]       start_idx;

  // Clamp the vertex count into 1 .. MAX_VERTICES.
  always_comb begin
    if (vcount_q == '0) begin
      n_c = CW'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      n_c = CW'(MAX_VERTICES);
    end else begin
      n_c = CW'(vcount_q);
    end
  end

  assign start_idx = VW'(start_q);
  assign w_sat     = (w_q > NO_EDGE) ? NO_EDGE : w_q;
  assign addr_ab   = AW'(32'(a_q) * MAX_VERTICES + 32'(b_q));
  assign addr_ba   = AW'(32'(b_q) * MAX_VERTICES + 32'(a_q));
  assign addr_add  = cmd_i.add_sel ? addr_ba : addr_ab;

  assign mat_raddr = cmd_i.add_rd ? addr_add : AW'(row_q + AW'(v_q));
  assign mat_waddr = cmd_i.clr_step ? sweep_q : addr_add;
  assign mat_wdata = cmd_i.clr_step ? NO_EDGE : w_sat;
  assign mat_we    = cmd_i.clr_step | (cmd_i.add_wr & (w_sat < w_rd_q));

  // Relax the key of the vertex in the evaluate stage, then track the minimum.
  assign ev_live = ev_valid_q & ~in_tree_q[ev_v_q];
  assign new_key = (w_rd_q < k_rd_q) ? w_rd_q : k_rd_q;
  assign better  = ~found_q | (new_key < best_key_q);

  assign key_we    = cmd_i.init_step | ev_live;
  assign key_waddr = cmd_i.init_step ? v_q : ev_v_q;
  assign key_wdata = cmd_i.init_step ? ((v_q == start_idx) ? '0 : NO_EDGE) : new_key;

  assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(best_key_q);
  assign total_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    sts_o               = '0;
    sts_o.sweep_last    = (sweep_q == SweepLast);
    sts_o.add_bad       = (32'(a_q) >= MAX_VERTICES) || (32'(b_q) >= MAX_VERTICES);
    sts_o.start_bad     = (32'(start_q) >= 32'(n_c));
    sts_o.single_vertex = (n_c == CW'(1));
    sts_o.v_last        = (CW'(v_q) == n_q - CW'(1));
    sts_o.last_round    = (rounds_q == CW'(1));
  end

  assign total_weight_o = out_q;

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      wmat_mem[mat_waddr] <= mat_wdata;
    end
    if (cmd_i.add_rd || cmd_i.scan_issue) begin
      w_rd_q <= wmat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (cmd_i.scan_issue) begin
      k_rd_q <= key_mem[v_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q   <= VCNT_RESET;
      sweep_q    <= '0;
      v_q        <= '0;
      n_q        <= '0;
      rounds_q   <= '0;
      ev_valid_q <= 1'b0;
      found_q    <= 1'b0;
      in_tree_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_vertex_count_i;
      end
      if (cmd_i.clr_step) begin
        sweep_q <= sts_o.sweep_last ? '0 : AW'(sweep_q + AW'(1));
      end
      ev_valid_q <= cmd_i.scan_issue;
      if (cmd_i.run_setup) begin
        v_q       <= '0;
        n_q       <= n_c;
        rounds_q  <= n_c - CW'(1);
        found_q   <= 1'b0;
        // Only the start vertex is in the tree.
        in_tree_q <= MAX_VERTICES'(1) << start_idx;
      end
      if (cmd_i.init_step || cmd_i.scan_issue) begin
        v_q <= sts_o.v_last ? '0 : VW'(v_q + VW'(1));
      end
      if (ev_live && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.round_next) begin
        found_q           <= 1'b0;
        rounds_q          <= rounds_q - CW'(1);
        in_tree_q[best_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      a_q     <= vertex_a_i;
      b_q     <= vertex_b_i;
      w_q     <= edge_weight_i;
      start_q <= start_vertex_i;
    end
    ev_v_q <= v_q;
    if (cmd_i.run_setup) begin
      total_q <= '0;
      row_q   <= AW'(32'(start_q) * MAX_VERTICES);
    end
    if (ev_live && better) begin
      best_q     <= ev_v_q;
      best_key_q <= new_key;
    end
    if (cmd_i.round_next) begin
      total_q <= total_sat;
      row_q   <= AW'(32'(best_q) * MAX_VERTICES);
    end
    if (cmd_i.out_load) begin
      out_q <= total_q;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pmw_ctrl.sv
// Controller: sequences clear sweeps, edge updates and Prim runs; owns result valid.
// Depends on pmw_pkg; commands pmw_datapath through dp_cmd_t and reads dp_sts_t.
`default_nettype none

module pmw_ctrl import pmw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [CMD_W-1:0] command_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire dp_sts_t          sts_i,
  output dp_cmd_t               cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          unique case (command_e'(command_i))
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_ADD:   state_d = ST_ADD_RD0;
            CMD_RUN:   state_d = ST_SETUP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD0: begin
        if (sts_i.add_bad) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.add_rd = 1'b1;
          state_d      = ST_ADD_WR0;
        end
      end
      ST_ADD_WR0: begin
        cmd_o.add_wr = 1'b1;
        state_d      = ST_ADD_RD1;
      end
      ST_ADD_RD1: begin
        cmd_o.add_rd  = 1'b1;
        cmd_o.add_sel = 1'b1;
        state_d       = ST_ADD_WR1;
      end
      ST_ADD_WR1: begin
        cmd_o.add_wr  = 1'b1;
        cmd_o.add_sel = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_SETUP: begin
        cmd_o.run_setup = 1'b1;
        if (sts_i.start_bad || sts_i.single_vertex) state_d = ST_DONE;
        else                                         state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.v_last) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.v_last) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.round_next = 1'b1;
        if (sts_i.last_round) state_d = ST_DONE;
        else                  state_d = ST_SCAN;
      end
      ST_DONE: begin
        // Hold the total until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/prim_mst_weight.sv
// Top level of the minimum spanning tree weight block.
// Instantiates pmw_ctrl and pmw_datapath; depends on pmw_pkg.
`default_nettype none

// Keeps an undirected graph of up to MAX_VERTICES vertices as a dense matrix of
// 17-bit weights (100000 means no edge) and answers a run command with the
// weight of the minimum spanning tree found by Prim's method from start_vertex.
// Each vertex the run cannot reach adds 100000; the total saturates at 2^23-1.
// Only a run gives a result beat; clear, add and the unused command give none.
// Sequences, with N the clamped vertex_count and M = MAX_VERTICES:
//   - after reset the matrix is swept to no-edge, all M*M entries,
//     during which in_stall_o stays high; vertex_count writes are taken anyway;
//   - clear command: all M*M entries, one matrix entry per cycle;
//   - add edge: after the accept, a read-modify-write of each of the
//     two symmetric entries through the matrix read and write ports;
//   - run: a setup step, a key load of the N vertices, then N-1 rounds of a
//     scan of the N vertices, a wait step and a next step, one key relaxed per
//     cycle through the matrix and key memory read ports, then the total goes
//     to the output register. A start vertex not below N answers 0 at once.
// The output register holds a finished total while the next command is taken;
// a second run waits for the first total to be taken before finishing.
// vertex_count is written through the cfg channel, which is always ready.

module prim_mst_weight import pmw_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Command channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [VTX_W-1:0]    vertex_a_i,
  input  wire logic [VTX_W-1:0]    vertex_b_i,
  input  wire logic [WEIGHT_W-1:0] edge_weight_i,
  input  wire logic [VTX_W-1:0]    start_vertex_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [TOTAL_W-1:0]       total_weight_o,
  // Configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [VCNT_W-1:0]   cfg_vertex_count_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Accept a configuration beat on any cycle.
  assign cfg_ready_o = 1'b1;

  pmw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  pmw_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (dp_cmd),
    .sts_o              (dp_sts),
    .vertex_a_i         (vertex_a_i),
    .vertex_b_i         (vertex_b_i),
    .edge_weight_i      (edge_weight_i),
    .start_vertex_i     (start_vertex_i),
    .cfg_we_i           (cfg_valid_i & cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .total_weight_o     (total_weight_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for prim_mst_weight: clear, add-edge and run beats
// with random pacing, each total checked against an in-bench Prim predictor.
// Depends on pmw_pkg and the prim_mst_weight RTL.

module tb_top;
  import pmw_pkg::*;

  localparam int MAX_V         = 64;
  // Quiet stretch after the last owed total: a full matrix sweep plus margin.
  localparam int SETTLE_CYCLES = MAX_V * MAX_V + 128;
  localparam int MAX_IDLE      = 14;
  localparam int DUE_DEPTH     = 256;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Command channel
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i      = '0;
  logic [VTX_W-1:0]    vertex_a_i     = '0;
  logic [VTX_W-1:0]    vertex_b_i     = '0;
  logic [WEIGHT_W-1:0] edge_weight_i  = '0;
  logic [VTX_W-1:0]    start_vertex_i = '0;

  // Result channel
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [TOTAL_W-1:0]  total_weight_o;

  // Configuration channel
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [VCNT_W-1:0]   cfg_vertex_count_i = '0;

  prim_mst_weight #(
    .MAX_VERTICES(MAX_V)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .vertex_a_i        (vertex_a_i),
    .vertex_b_i        (vertex_b_i),
    .edge_weight_i     (edge_weight_i),
    .start_vertex_i    (start_vertex_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .total_weight_o    (total_weight_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_vertex_count_i(cfg_vertex_count_i)
  );

  // Predictor state: its own copy of the matrix and the vertex count.
  logic [WEIGHT_W-1:0] graph_w [MAX_V][MAX_V];
  logic [VCNT_W-1:0]   vcount_model;
  // Totals owed by accepted run beats, oldest first; empty when the
  // write and read pointers meet.
  logic [TOTAL_W-1:0]  totals_due [DUE_DEPTH];
  logic [7:0]          due_wr = '0;
  logic [7:0]          due_rd = '0;

  int fail_count;
  // Set to drop all random gaps (sender) or stalls (receiver) for a phase.
  bit tx_steady;
  bit rx_steady;

  // Clamp the configured count to 1..MAX_V, as the block does.
  function automatic int active_vertices();
    if (vcount_model == '0) return 1;
    if (vcount_model > MAX_V) return MAX_V;
    return int'(vcount_model);
  endfunction

  function automatic void clear_graph_model();
    int r;
    int c;
    for (r = 0; r < MAX_V; r++)
      for (c = 0; c < MAX_V; c++)
        graph_w[r][c] = NO_EDGE;
  endfunction

  // Prim over the first N vertices; each unreachable vertex adds NO_EDGE.
  function automatic logic [TOTAL_W-1:0] mst_total(input logic [VTX_W-1:0] root);
    int n;
    int v;
    int cur;
    int best;
    int left;
    int sum;
    logic [WEIGHT_W-1:0] key [MAX_V];
    bit joined [MAX_V];
    n = active_vertices();
    // A root outside the graph in use answers zero.
    if (int'(root) >= n) return '0;
    for (v = 0; v < MAX_V; v++) begin
      key[v]    = NO_EDGE;
      joined[v] = 1'b0;
    end
    key[root]    = '0;
    cur          = int'(root);
    joined[cur]  = 1'b1;
    left         = n - 1;
    sum          = 0;
    while (left > 0) begin
      best = -1;
      for (v = 0; v < n; v++) begin
        if (!joined[v]) begin
          if (graph_w[cur][v] < key[v]) key[v] = graph_w[cur][v];
          // Strict compare keeps the lowest index on ties.
          if (best < 0 || key[v] < key[best]) best = v;
        end
      end
      sum += int'(key[best]);
      if (sum > int'(TOTAL_MAX)) sum = int'(TOTAL_MAX);
      cur         = best;
      joined[cur] = 1'b1;
      left--;
    end
    return sum[TOTAL_W-1:0];
  endfunction

  // Advance the predictor by one accepted command beat.
  function automatic void apply_command(input logic [CMD_W-1:0]    cmd,
                                        input logic [VTX_W-1:0]    a,
                                        input logic [VTX_W-1:0]    b,
                                        input logic [WEIGHT_W-1:0] w,
                                        input logic [VTX_W-1:0]    root);
    logic [WEIGHT_W-1:0] wc;
    case (cmd)
      CMD_CLEAR: clear_graph_model();
      CMD_ADD: begin
        // Anything heavier than NO_EDGE means no edge; keep the lighter edge.
        wc = (w > NO_EDGE) ? NO_EDGE : w;
        if (wc < graph_w[a][b]) graph_w[a][b] = wc;
        if (wc < graph_w[b][a]) graph_w[b][a] = wc;
      end
      CMD_RUN: begin
        totals_due[due_wr] = mst_total(root);
        due_wr             = due_wr + 8'd1;
      end
      default: ;
    endcase
  endfunction

  // Send one command beat. Valid is left high after the accept so a
  // back-to-back beat never lowers and raises it in one step; anything
  // else that follows must drop it first.
  task automatic issue_command(input logic [CMD_W-1:0]    cmd,
                               input logic [VTX_W-1:0]    a,
                               input logic [VTX_W-1:0]    b,
                               input logic [WEIGHT_W-1:0] w,
                               input logic [VTX_W-1:0]    root);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    vertex_a_i     <= a;
    vertex_b_i     <= b;
    edge_weight_i  <= w;
    start_vertex_i <= root;
    // Hold the payload until the block stops stalling.
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    apply_command(cmd, a, b, w, root);
  endtask

  // Drop valid, let every owed total arrive, then wait out a possible sweep.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (due_wr != due_rd) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [VCNT_W-1:0] value);
    quiesce();
    cfg_valid_i        <= 1'b1;
    cfg_vertex_count_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i  <= 1'b0;
    vcount_model = value;
  endtask

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return WEIGHT_W'($urandom_range(0, 15));
      6, 7:             return WEIGHT_W'($urandom_range(0, 100000));
      8:                return WEIGHT_W'($urandom_range(100000, 131071));
      default:          return WEIGHT_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [VTX_W-1:0] rand_vertex();
    return VTX_W'($urandom_range(0, 63));
  endfunction

  // Runs on the empty graph left by the reset sweep: every vertex unreachable.
  task automatic test_empty_graph();
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd0);
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd63);
  endtask

  // Weight extremes, heavy weight, parallel edges, self loop, top vertex.
  task automatic test_edge_rules();
    issue_command(CMD_ADD, 6'd0,  6'd1,  17'd0,      6'd0);
    issue_command(CMD_ADD, 6'd1,  6'd2,  17'd100000, 6'd63);
    issue_command(CMD_ADD, 6'd2,  6'd3,  17'd131071, 6'd0);
    issue_command(CMD_ADD, 6'd3,  6'd4,  17'd9,      6'd0);
    issue_command(CMD_ADD, 6'd4,  6'd3,  17'd5,      6'd0);
    issue_command(CMD_ADD, 6'd3,  6'd4,  17'd12,     6'd0);
    issue_command(CMD_ADD, 6'd5,  6'd5,  17'd1,      6'd0);
    issue_command(CMD_ADD, 6'd63, 6'd62, 17'd99999,  6'd0);
    issue_command(CMD_ADD, 6'd0,  6'd63, 17'd1,      6'd0);
    // Equal keys out of vertex 0: the lower index must win.
    issue_command(CMD_ADD, 6'd0,  6'd7,  17'd1,      6'd0);
    issue_command(CMD_RUN, 6'd0,  6'd0,  17'd0,      6'd0);
    issue_command(CMD_RUN, 6'd63, 6'd63, 17'd131071, 6'd63);
  endtask

  // Count extremes and clamping, starts out of range, endpoints above the
  // count, the unused command and a clear.
  task automatic test_vertex_count_limits();
    write_vertex_count(7'd1);
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd0);
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd63);
    write_vertex_count(7'd0);
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd0);
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd1);
    write_vertex_count(7'd127);
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd5);
    write_vertex_count(7'd6);
    issue_command(CMD_ADD, 6'd2, 6'd40, 17'd3, 6'd0);
    issue_command(CMD_UNUSED, 6'd63, 6'd63, 17'h1FFFF, 6'd63);
    issue_command(CMD_RUN, 6'd0, 6'd0, 17'd0, 6'd5);
    issue_command(CMD_RUN, 6'd0, 6'd0, 17'd0, 6'd6);
    issue_command(CMD_CLEAR, rand_vertex(), rand_vertex(), rand_weight(), 6'd0);
    issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), 6'd2);
  endtask

  // Random graphs, phase by phase: mostly a clear, edges inside the graph in
  // use and a few runs, with some noise beats mixed in.
  task automatic test_random_graphs();
    int phase;
    int n;
    int edges;
    int runs;
    logic [VCNT_W-1:0] count;
    logic [VTX_W-1:0]  root;
    for (phase = 0; phase < 9; phase++) begin
      case ($urandom_range(0, 7))
        0:       count = 7'd64;
        1:       count = VCNT_W'($urandom_range(65, 127));
        2:       count = VCNT_W'($urandom_range(0, 1));
        default: count = VCNT_W'($urandom_range(2, 12));
      endcase
      write_vertex_count(count);
      n = active_vertices();
      // Mix paced phases with back-to-back ones on either side.
      tx_steady = (phase % 3 == 2);
      rx_steady = (phase % 4 == 3);
      if ($urandom_range(0, 3) != 0)
        issue_command(CMD_CLEAR, rand_vertex(), rand_vertex(), rand_weight(),
                      rand_vertex());
      edges = $urandom_range(4, 14);
      repeat (edges) begin
        if ($urandom_range(0, 9) == 0)
          issue_command(CMD_W'($urandom_range(0, 3)), rand_vertex(),
                        rand_vertex(), rand_weight(), rand_vertex());
        else
          issue_command(CMD_ADD, VTX_W'($urandom_range(0, n - 1)),
                        VTX_W'($urandom_range(0, n - 1)), rand_weight(),
                        rand_vertex());
      end
      runs = $urandom_range(2, 3);
      repeat (runs) begin
        root = ($urandom_range(0, 5) == 0) ? rand_vertex()
                                           : VTX_W'($urandom_range(0, n - 1));
        issue_command(CMD_RUN, rand_vertex(), rand_vertex(), rand_weight(), root);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: draw a stall per beat, then take and check the next total.
  initial begin : total_sink
    int hold;
    logic [TOTAL_W-1:0] want;
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (due_wr == due_rd) begin
        $error("total_weight: expected none, actual %0d", total_weight_o);
        fail_count++;
      end else begin
        want   = totals_due[due_rd];
        due_rd = due_rd + 8'd1;
        if (total_weight_o !== want) begin
          $error("total_weight: expected %0d, actual %0d", want, total_weight_o);
          fail_count++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : main_seq
    fail_count   = 0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    vcount_model = VCNT_RESET;
    clear_graph_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_graph();
    test_edge_rules();
    test_vertex_count_limits();
    test_random_graphs();
    quiesce();
    if (fail_count == 0 && due_wr == due_rd) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/pmw_pkg.sv
hdl/pmw_datapath.sv
hdl/pmw_ctrl.sv
hdl/prim_mst_weight.sv
tb/tb_top.sv
